FILE: sv/nwp_pkg.sv
`default_nettype none
package nwp_pkg;

  // classified word handed from the front end to the parser
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       is_digit;
    logic       is_alpha;
    logic       is_crlf;
    logic [3:0] dval;
  } nwp_word_t;

  localparam logic [4:0] KEYWORD_MAX   = 5'd24;
  localparam logic [4:0] NUMBER_DIGITS = 5'd4;
  localparam logic [4:0] UPI_MAX       = 5'd16;
  localparam logic [4:0] SEL_MAX       = 5'd5;
  localparam logic [4:0] DATE_MAX      = 5'd5;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DC1 = 8'h11;
  localparam logic [7:0] CH_DC2 = 8'h12;
  localparam logic [7:0] CH_DC3 = 8'h13;
  localparam logic [7:0] CH_DC4 = 8'h14;
  localparam logic [7:0] CH_SYN = 8'h16;
  localparam logic [7:0] CH_US  = 8'h1F;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DASH = 8'h2D;

  localparam logic [3:0] TAG_DELIM   = 4'd0;
  localparam logic [3:0] TAG_SERVICE = 4'd1;
  localparam logic [3:0] TAG_STORY   = 4'd2;
  localparam logic [3:0] TAG_UPI     = 4'd3;
  localparam logic [3:0] TAG_SEL     = 4'd4;
  localparam logic [3:0] TAG_PRI     = 4'd5;
  localparam logic [3:0] TAG_CAT     = 4'd6;
  localparam logic [3:0] TAG_KEYWORD = 4'd7;
  localparam logic [3:0] TAG_VERSION = 4'd8;
  localparam logic [3:0] TAG_REF     = 4'd9;
  localparam logic [3:0] TAG_DATE    = 4'd10;
  localparam logic [3:0] TAG_COUNT   = 4'd11;
  localparam logic [3:0] TAG_BODY    = 4'd12;
  localparam logic [3:0] TAG_TIME    = 4'd13;

  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  localparam logic [2:0] KIND_BODY_TEXT  = 3'd1;
  localparam logic [2:0] KIND_BODY_TAB   = 3'd2;
  localparam logic [2:0] KIND_AGATE_TEXT = 3'd3;
  localparam logic [2:0] KIND_AGATE_TAB  = 3'd4;

  typedef enum logic [3:0] {
    ERR_NONE  = 4'd0,
    ERR_SOH   = 4'd1,
    ERR_DIGIT = 4'd2,
    ERR_US    = 4'd3,
    ERR_LF    = 4'd4,
    ERR_ALPHA = 4'd5,
    ERR_SPACE = 4'd6,
    ERR_DC12  = 4'd7,
    ERR_DC34  = 4'd8,
    ERR_STX   = 4'd9,
    ERR_ETX   = 4'd10,
    ERR_EOT   = 4'd11,
    ERR_EOF   = 4'd12
  } nwp_err_t;

  typedef enum logic [26:0] {
    PH_LEAD     = 27'd1 << 0,
    PH_SVC      = 27'd1 << 1,
    PH_FIRSTDIG = 27'd1 << 2,
    PH_STORY    = 27'd1 << 3,
    PH_UPI      = 27'd1 << 4,
    PH_SEL      = 27'd1 << 5,
    PH_SELLF    = 27'd1 << 6,
    PH_PRI      = 27'd1 << 7,
    PH_SP1      = 27'd1 << 8,
    PH_CAT      = 27'd1 << 9,
    PH_FMT      = 27'd1 << 10,
    PH_FMTB     = 27'd1 << 11,
    PH_FMTA     = 27'd1 << 12,
    PH_SP2      = 27'd1 << 13,
    PH_KW       = 27'd1 << 14,
    PH_VER      = 27'd1 << 15,
    PH_XSP      = 27'd1 << 16,
    PH_REF      = 27'd1 << 17,
    PH_DATE     = 27'd1 << 18,
    PH_WC       = 27'd1 << 19,
    PH_WCCR     = 27'd1 << 20,
    PH_STX      = 27'd1 << 21,
    PH_BODY     = 27'd1 << 22,
    PH_TLEAD    = 27'd1 << 23,
    PH_TIME     = 27'd1 << 24,
    PH_TTRAIL   = 27'd1 << 25,
    PH_TAIL     = 27'd1 << 26
  } nwp_phase_t;

  // what a phase was waiting for when the stream ends early
  function automatic nwp_err_t eof_code(input nwp_phase_t ph);
    nwp_err_t e;
    case (ph)
      PH_LEAD:                              e = ERR_SOH;
      PH_SVC, PH_FIRSTDIG:                  e = ERR_DIGIT;
      PH_STORY, PH_UPI:                     e = ERR_US;
      PH_SEL, PH_SELLF:                     e = ERR_LF;
      PH_PRI, PH_CAT:                       e = ERR_ALPHA;
      PH_FMT:                               e = ERR_DC34;
      PH_FMTB, PH_FMTA:                     e = ERR_DC12;
      PH_SP1, PH_SP2, PH_KW, PH_VER,
      PH_XSP, PH_REF, PH_DATE:              e = ERR_SPACE;
      PH_WC, PH_WCCR, PH_STX:               e = ERR_STX;
      PH_BODY:                              e = ERR_ETX;
      PH_TLEAD, PH_TIME, PH_TTRAIL:         e = ERR_EOT;
      default:                              e = ERR_NONE;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: sv/nwp_front.sv
`default_nettype none
module nwp_front
  import nwp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_stream,
  output logic            push,
  output nwp_word_t       push_word,
  input  wire logic       q_full
);

  logic      fv;
  nwp_word_t fw;
  nwp_word_t cls;

  always_comb begin
    cls.data     = in_byte;
    cls.eos      = end_of_stream;
    cls.is_digit = in_byte inside {[8'h30:8'h39]};
    cls.is_alpha = in_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    cls.is_crlf  = (in_byte == CH_CR) || (in_byte == CH_LF);
    cls.dval     = in_byte[3:0];
  end

  assign push      = fv && !q_full;
  assign push_word = fw;
  assign in_ready  = !fv || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fw <= cls;
    end
  end

endmodule
`default_nettype wire

FILE: sv/nwp_queue.sv
`default_nettype none
module nwp_queue
  import nwp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire nwp_word_t push_word,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output nwp_word_t      head
);

  nwp_word_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule
`default_nettype wire

FILE: sv/nwp_back.sv
`default_nettype none
module nwp_back
  import nwp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        not_empty,
  input  wire nwp_word_t   w,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       field_tag,
  output logic [7:0]       char_out,
  output logic [13:0]      story_value,
  output logic [13:0]      count_value,
  output logic [2:0]       format_kind,
  output logic [1:0]       status,
  output logic [3:0]       error_code
);

  nwp_phase_t  phase, phase_next;
  logic [4:0]  char_counter, char_counter_next;
  logic [13:0] story_acc, story_acc_next;
  logic [13:0] words_acc, words_acc_next;
  logic [2:0]  kind_reg, kind_reg_next;
  logic        version_empty, version_empty_next;
  nwp_err_t    sticky_error, sticky_error_next;

  logic [3:0]  tag;
  logic [1:0]  st;
  nwp_err_t    err;
  logic [7:0]  ch;
  logic [13:0] story_o, words_o;
  logic [2:0]  kind_o;
  logic [4:0]  cnt_inc;
  logic [13:0] story_x10, words_x10;
  logic [7:0]  c;

  assign pop = not_empty && (!out_valid || out_ready);
  assign c   = w.data;
  assign cnt_inc = char_counter + 5'd1;
  assign story_x10 = {story_acc[10:0], 3'b000} + {story_acc[12:0], 1'b0} + {10'd0, w.dval};
  assign words_x10 = {words_acc[10:0], 3'b000} + {words_acc[12:0], 1'b0} + {10'd0, w.dval};

  always_comb begin
    phase_next         = phase;
    char_counter_next  = char_counter;
    story_acc_next     = story_acc;
    words_acc_next     = words_acc;
    kind_reg_next      = kind_reg;
    version_empty_next = version_empty;
    sticky_error_next  = sticky_error;
    tag   = TAG_DELIM;
    st    = ST_PARSING;
    err   = ERR_NONE;
    ch    = c;
    story_o = story_acc;
    words_o = words_acc;
    kind_o  = kind_reg;

    if (w.eos) begin
      ch = 8'd0;
      if (sticky_error != ERR_NONE) begin
        st  = ST_ERROR;
        err = sticky_error;
      end else if (phase == PH_TAIL) begin
        st = ST_DONE;
      end else begin
        st  = ST_ERROR;
        err = eof_code(phase);
      end
      phase_next         = PH_LEAD;
      char_counter_next  = 5'd0;
      story_acc_next     = 14'd0;
      words_acc_next     = 14'd0;
      kind_reg_next      = 3'd0;
      version_empty_next = 1'b0;
      sticky_error_next  = ERR_NONE;
    end else begin
      if (sticky_error == ERR_NONE) begin
        case (phase)
          PH_LEAD: begin
            if (c == CH_SYN || w.is_crlf) phase_next = PH_LEAD;
            else if (c == CH_SOH) phase_next = PH_SVC;
            else err = ERR_SOH;
          end
          PH_SVC, PH_FIRSTDIG: begin
            if (phase == PH_SVC && w.is_alpha) begin
              tag = TAG_SERVICE;
              phase_next = PH_FIRSTDIG;
            end else if (w.is_digit) begin
              tag = TAG_STORY;
              story_acc_next = {10'd0, w.dval};
              char_counter_next = 5'd1;
              phase_next = PH_STORY;
            end else err = ERR_DIGIT;
          end
          PH_STORY: begin
            if (w.is_digit && char_counter < NUMBER_DIGITS) begin
              tag = TAG_STORY;
              story_acc_next = story_x10;
              char_counter_next = cnt_inc;
            end else if (c == CH_US) begin
              char_counter_next = 5'd0;
              phase_next = PH_SEL;
            end else begin
              // an extra digit or any other byte opens the UPI
              tag = TAG_UPI;
              char_counter_next = 5'd1;
              phase_next = PH_UPI;
            end
          end
          PH_UPI: begin
            if (c == CH_US) begin
              char_counter_next = 5'd0;
              phase_next = PH_SEL;
            end else if (char_counter < UPI_MAX) begin
              tag = TAG_UPI;
              char_counter_next = cnt_inc;
            end else err = ERR_US;
          end
          PH_SEL: begin
            if (w.is_alpha || c == CH_DASH) begin
              if (char_counter < SEL_MAX) begin
                tag = TAG_SEL;
                char_counter_next = cnt_inc;
              end else err = ERR_LF;
            end else if (c == CH_CR) phase_next = PH_SELLF;
            else if (c == CH_LF) phase_next = PH_PRI;
            else err = ERR_LF;
          end
          PH_SELLF: begin
            if (c == CH_LF) phase_next = PH_PRI;
            else err = ERR_LF;
          end
          PH_PRI: begin
            if (w.is_alpha) begin
              tag = TAG_PRI;
              phase_next = PH_SP1;
            end else err = ERR_ALPHA;
          end
          PH_SP1: begin
            if (c == CH_SP) phase_next = PH_CAT;
            else err = ERR_SPACE;
          end
          PH_CAT: begin
            if (w.is_alpha) begin
              tag = TAG_CAT;
              phase_next = PH_FMT;
            end else err = ERR_ALPHA;
          end
          PH_FMT: begin
            if (c == CH_DC3) phase_next = PH_FMTB;
            else if (c == CH_DC4) phase_next = PH_FMTA;
            else err = ERR_DC34;
          end
          PH_FMTB: begin
            if (c == CH_DC1) begin
              kind_reg_next = KIND_BODY_TEXT;
              phase_next = PH_SP2;
            end else if (c == CH_DC2) begin
              kind_reg_next = KIND_BODY_TAB;
              phase_next = PH_SP2;
            end else err = ERR_DC12;
          end
          PH_FMTA: begin
            if (c == CH_DC1) begin
              kind_reg_next = KIND_AGATE_TEXT;
              phase_next = PH_SP2;
            end else if (c == CH_DC2) begin
              kind_reg_next = KIND_AGATE_TAB;
              phase_next = PH_SP2;
            end else err = ERR_DC12;
          end
          PH_SP2: begin
            if (c == CH_SP) begin
              char_counter_next = 5'd0;
              phase_next = PH_KW;
            end else err = ERR_SPACE;
          end
          PH_KW: begin
            if (w.is_alpha || w.is_digit || c == CH_DASH) begin
              if (char_counter < KEYWORD_MAX) begin
                tag = TAG_KEYWORD;
                char_counter_next = cnt_inc;
              end else err = ERR_SPACE;
            end else if (c == CH_SP) begin
              version_empty_next = 1'b1;
              phase_next = PH_VER;
            end else err = ERR_SPACE;
          end
          PH_VER: begin
            if (c == CH_SP) phase_next = version_empty ? PH_XSP : PH_REF;
            else begin
              tag = TAG_VERSION;
              version_empty_next = 1'b0;
            end
          end
          PH_XSP: begin
            // empty version may carry one extra space
            if (c != CH_SP) tag = TAG_REF;
            phase_next = PH_REF;
          end
          PH_REF: begin
            if (c == CH_SP) begin
              char_counter_next = 5'd0;
              phase_next = PH_DATE;
            end else tag = TAG_REF;
          end
          PH_DATE: begin
            if (w.is_digit || c == CH_DASH) begin
              if (char_counter < DATE_MAX) begin
                tag = TAG_DATE;
                char_counter_next = cnt_inc;
              end else err = ERR_SPACE;
            end else if (c == CH_SP) begin
              char_counter_next = 5'd0;
              words_acc_next = 14'd0;
              phase_next = PH_WC;
            end else err = ERR_SPACE;
          end
          PH_WC: begin
            if (w.is_digit) begin
              if (char_counter < NUMBER_DIGITS) begin
                tag = TAG_COUNT;
                words_acc_next = words_x10;
                char_counter_next = cnt_inc;
              end else err = ERR_STX;
            end else if (c == CH_CR) phase_next = PH_WCCR;
            else if (c == CH_LF) phase_next = PH_STX;
            else if (c == CH_STX) phase_next = PH_BODY;
            else err = ERR_STX;
          end
          PH_WCCR: begin
            if (c == CH_LF) phase_next = PH_STX;
            else if (c == CH_STX) phase_next = PH_BODY;
            else err = ERR_STX;
          end
          PH_STX: begin
            if (c == CH_STX) phase_next = PH_BODY;
            else err = ERR_STX;
          end
          PH_BODY: begin
            if (c == CH_ETX) phase_next = PH_TLEAD;
            else tag = TAG_BODY;
          end
          PH_TLEAD: begin
            if (!w.is_crlf) begin
              tag = TAG_TIME;
              phase_next = PH_TIME;
            end
          end
          PH_TIME: begin
            if (w.is_crlf) phase_next = PH_TTRAIL;
            else tag = TAG_TIME;
          end
          PH_TTRAIL: begin
            if (w.is_crlf) phase_next = PH_TTRAIL;
            else if (c == CH_EOT) phase_next = PH_TAIL;
            else err = ERR_EOT;
          end
          PH_TAIL: begin
            if (!w.is_crlf) err = ERR_EOF;
          end
          default: err = ERR_SOH;
        endcase
        if (err != ERR_NONE) sticky_error_next = err;
      end
      if (sticky_error_next != ERR_NONE) begin
        st  = ST_ERROR;
        err = sticky_error_next;
        tag = TAG_DELIM;
      end
      story_o = story_acc_next;
      words_o = words_acc_next;
      kind_o  = kind_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      char_counter  <= 5'd0;
      story_acc     <= 14'd0;
      words_acc     <= 14'd0;
      kind_reg      <= 3'd0;
      version_empty <= 1'b0;
      sticky_error  <= ERR_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        char_counter  <= char_counter_next;
        story_acc     <= story_acc_next;
        words_acc     <= words_acc_next;
        kind_reg      <= kind_reg_next;
        version_empty <= version_empty_next;
        sticky_error  <= sticky_error_next;
      end
      if (pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      field_tag   <= tag;
      char_out    <= ch;
      story_value <= story_o;
      count_value <= words_o;
      format_kind <= kind_o;
      status      <= st;
      error_code  <= err;
    end
  end

endmodule
`default_nettype wire

FILE: sv/news_wire_story_header_parser_core.sv
`default_nettype none
// News-wire story parser for the ANPA-1312 layout. Feed one story byte per
// word on the input channel, or a word with end_of_stream set to close the
// story; every input word yields exactly one result word that tags the byte
// with its field and carries the running story number, word count, format
// kind, and a status/error code. Sustained rate is one byte per clock while
// neither side stalls; a byte's result passes the front register, two-entry
// queue and parser output register before it is valid. The per-byte parser
// step, a registered state update, sets the rate. Either side may stall freely.
module news_wire_story_header_parser_core
  import nwp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_stream,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       field_tag,
  output logic [7:0]       char_out,
  output logic [13:0]      story_value,
  output logic [13:0]      count_value,
  output logic [2:0]       format_kind,
  output logic [1:0]       status,
  output logic [3:0]       error_code
);

  logic      push;
  nwp_word_t push_word;
  logic      q_full;
  logic      pop;
  logic      q_not_empty;
  nwp_word_t q_head;

  nwp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_stream(end_of_stream),
    .push         (push),
    .push_word    (push_word),
    .q_full       (q_full)
  );

  nwp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_word(push_word),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  nwp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (q_not_empty),
    .w          (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .field_tag  (field_tag),
    .char_out   (char_out),
    .story_value(story_value),
    .count_value(count_value),
    .format_kind(format_kind),
    .status     (status),
    .error_code (error_code)
  );

endmodule
`default_nettype wire

FILE: sim/news_wire_story_header_parser_core_tb.sv
`timescale 1ns / 100ps

module news_wire_story_header_parser_core_tb;
  import nwp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_ITEMS = 1650;

  typedef struct packed {
    logic [3:0]  tag;
    logic [7:0]  ch;
    logic [13:0] story;
    logic [13:0] words;
    logic [2:0]  kind;
    logic [1:0]  st;
    logic [3:0]  err;
  } tag_word_t;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         typed;
    tag_word_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  field_tag;
  logic [7:0]  char_out;
  logic [13:0] story_value;
  logic [13:0] count_value;
  logic [2:0]  format_kind;
  logic [1:0]  status;
  logic [3:0]  error_code;

  news_wire_story_header_parser_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte(in_byte), .end_of_stream(end_of_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .field_tag(field_tag), .char_out(char_out),
    .story_value(story_value), .count_value(count_value),
    .format_kind(format_kind), .status(status), .error_code(error_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser shadow state
  nwp_phase_t  ph;
  logic [4:0]  cnt;
  logic [13:0] story_acc;
  logic [13:0] words_acc;
  logic [2:0]  kind;
  logic        ver_empty;
  nwp_err_t    held;

  tag_word_t   pending_results[$];
  dir_row_t    dir_rows[$];
  logic [8:0]  story_q[$];
  int          mismatch_count = 0;
  int          sent_items = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  function automatic void clear_parser();
    ph = PH_LEAD;
    cnt = '0;
    story_acc = '0;
    words_acc = '0;
    kind = '0;
    ver_empty = 1'b0;
    held = ERR_NONE;
  endfunction

  // what each phase still needed when the story is cut short
  function automatic nwp_err_t ended_early_code(input nwp_phase_t p);
    case (p)
      PH_LEAD:                      return ERR_SOH;
      PH_SVC, PH_FIRSTDIG:          return ERR_DIGIT;
      PH_STORY, PH_UPI:             return ERR_US;
      PH_SEL, PH_SELLF:             return ERR_LF;
      PH_PRI, PH_CAT:               return ERR_ALPHA;
      PH_FMT:                       return ERR_DC34;
      PH_FMTB, PH_FMTA:             return ERR_DC12;
      PH_WC, PH_WCCR, PH_STX:       return ERR_STX;
      PH_BODY:                      return ERR_ETX;
      PH_TLEAD, PH_TIME, PH_TTRAIL: return ERR_EOT;
      PH_TAIL:                      return ERR_NONE;
      default:                      return ERR_SPACE;
    endcase
  endfunction

  function automatic tag_word_t parse_byte(input logic [7:0] c, input logic eos);
    tag_word_t  r;
    logic [3:0] tag;
    nwp_err_t   e;
    logic       dig, alp, crlf;
    dig  = (c >= "0") && (c <= "9");
    alp  = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    crlf = (c == CH_CR) || (c == CH_LF);
    tag  = TAG_DELIM;
    e    = ERR_NONE;
    if (eos) begin
      r.tag = TAG_DELIM;
      r.ch = 8'h00;
      r.story = story_acc;
      r.words = words_acc;
      r.kind = kind;
      if (held != ERR_NONE) begin
        r.st = ST_ERROR;
        r.err = held;
      end else if (ph == PH_TAIL) begin
        r.st = ST_DONE;
        r.err = ERR_NONE;
      end else begin
        r.st = ST_ERROR;
        r.err = ended_early_code(ph);
      end
      clear_parser();
      return r;
    end
    if (held == ERR_NONE) begin
      case (ph)
        PH_LEAD: begin
          if (c == CH_SYN || crlf) ;
          else if (c == CH_SOH) ph = PH_SVC;
          else e = ERR_SOH;
        end
        PH_SVC, PH_FIRSTDIG: begin
          if (ph == PH_SVC && alp) begin
            tag = TAG_SERVICE;
            ph = PH_FIRSTDIG;
          end else if (dig) begin
            tag = TAG_STORY;
            story_acc = {10'd0, c[3:0]};
            cnt = 5'd1;
            ph = PH_STORY;
          end else e = ERR_DIGIT;
        end
        PH_STORY: begin
          if (dig && cnt < NUMBER_DIGITS) begin
            tag = TAG_STORY;
            story_acc = story_acc * 14'd10 + {10'd0, c[3:0]};
            cnt = cnt + 5'd1;
          end else if (c == CH_US) begin
            cnt = '0;
            ph = PH_SEL;
          end else begin
            // an extra digit or any other byte opens the UPI
            tag = TAG_UPI;
            cnt = 5'd1;
            ph = PH_UPI;
          end
        end
        PH_UPI: begin
          if (c == CH_US) begin
            cnt = '0;
            ph = PH_SEL;
          end else if (cnt < UPI_MAX) begin
            tag = TAG_UPI;
            cnt = cnt + 5'd1;
          end else e = ERR_US;
        end
        PH_SEL: begin
          if (alp || c == CH_DASH) begin
            if (cnt < SEL_MAX) begin
              tag = TAG_SEL;
              cnt = cnt + 5'd1;
            end else e = ERR_LF;
          end else if (c == CH_CR) ph = PH_SELLF;
          else if (c == CH_LF) ph = PH_PRI;
          else e = ERR_LF;
        end
        PH_SELLF: if (c == CH_LF) ph = PH_PRI; else e = ERR_LF;
        PH_PRI: begin
          if (alp) begin
            tag = TAG_PRI;
            ph = PH_SP1;
          end else e = ERR_ALPHA;
        end
        PH_SP1: if (c == CH_SP) ph = PH_CAT; else e = ERR_SPACE;
        PH_CAT: begin
          if (alp) begin
            tag = TAG_CAT;
            ph = PH_FMT;
          end else e = ERR_ALPHA;
        end
        PH_FMT: begin
          if (c == CH_DC3) ph = PH_FMTB;
          else if (c == CH_DC4) ph = PH_FMTA;
          else e = ERR_DC34;
        end
        PH_FMTB, PH_FMTA: begin
          if (c == CH_DC1) begin
            kind = (ph == PH_FMTB) ? KIND_BODY_TEXT : KIND_AGATE_TEXT;
            ph = PH_SP2;
          end else if (c == CH_DC2) begin
            kind = (ph == PH_FMTB) ? KIND_BODY_TAB : KIND_AGATE_TAB;
            ph = PH_SP2;
          end else e = ERR_DC12;
        end
        PH_SP2: begin
          if (c == CH_SP) begin
            cnt = '0;
            ph = PH_KW;
          end else e = ERR_SPACE;
        end
        PH_KW: begin
          if (alp || dig || c == CH_DASH) begin
            if (cnt < KEYWORD_MAX) begin
              tag = TAG_KEYWORD;
              cnt = cnt + 5'd1;
            end else e = ERR_SPACE;
          end else if (c == CH_SP) begin
            ver_empty = 1'b1;
            ph = PH_VER;
          end else e = ERR_SPACE;
        end
        PH_VER: begin
          if (c == CH_SP) ph = ver_empty ? PH_XSP : PH_REF;
          else begin
            tag = TAG_VERSION;
            ver_empty = 1'b0;
          end
        end
        PH_XSP: begin
          if (c != CH_SP) tag = TAG_REF;
          ph = PH_REF;
        end
        PH_REF: begin
          if (c == CH_SP) begin
            cnt = '0;
            ph = PH_DATE;
          end else tag = TAG_REF;
        end
        PH_DATE: begin
          if (dig || c == CH_DASH) begin
            if (cnt < DATE_MAX) begin
              tag = TAG_DATE;
              cnt = cnt + 5'd1;
            end else e = ERR_SPACE;
          end else if (c == CH_SP) begin
            cnt = '0;
            words_acc = '0;
            ph = PH_WC;
          end else e = ERR_SPACE;
        end
        PH_WC: begin
          if (dig) begin
            if (cnt < NUMBER_DIGITS) begin
              tag = TAG_COUNT;
              words_acc = words_acc * 14'd10 + {10'd0, c[3:0]};
              cnt = cnt + 5'd1;
            end else e = ERR_STX;
          end else if (c == CH_CR) ph = PH_WCCR;
          else if (c == CH_LF) ph = PH_STX;
          else if (c == CH_STX) ph = PH_BODY;
          else e = ERR_STX;
        end
        PH_WCCR: begin
          if (c == CH_LF) ph = PH_STX;
          else if (c == CH_STX) ph = PH_BODY;
          else e = ERR_STX;
        end
        PH_STX: if (c == CH_STX) ph = PH_BODY; else e = ERR_STX;
        PH_BODY: if (c == CH_ETX) ph = PH_TLEAD; else tag = TAG_BODY;
        PH_TLEAD: begin
          // first non CR/LF byte is time, even EOT
          if (!crlf) begin
            tag = TAG_TIME;
            ph = PH_TIME;
          end
        end
        PH_TIME: if (crlf) ph = PH_TTRAIL; else tag = TAG_TIME;
        PH_TTRAIL: begin
          if (crlf) ;
          else if (c == CH_EOT) ph = PH_TAIL;
          else e = ERR_EOT;
        end
        PH_TAIL: if (!crlf) e = ERR_EOF;
        default: e = ERR_SOH;
      endcase
      if (e != ERR_NONE) held = e;
    end
    r.ch = c;
    r.story = story_acc;
    r.words = words_acc;
    r.kind = kind;
    if (held != ERR_NONE) begin
      r.tag = TAG_DELIM;
      r.st = ST_ERROR;
      r.err = held;
    end else begin
      r.tag = tag;
      r.st = ST_PARSING;
      r.err = ERR_NONE;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input tag_word_t got, input tag_word_t want);
    mismatch_count++;
    $display({"%0t %s: got tag=%0d ch=%02h story=%0d words=%0d kind=%0d st=%0d err=%0d",
              " | want tag=%0d ch=%02h story=%0d words=%0d kind=%0d st=%0d err=%0d"},
             $time, what, got.tag, got.ch, got.story, got.words, got.kind, got.st, got.err,
             want.tag, want.ch, want.story, want.words, want.kind, want.st, want.err);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly short, sometimes at the field limit, sometimes one past it
  function automatic int pick_len(input int typ, input int hard);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, typ);
    if (r < 95) return hard;
    return hard + 1;
  endfunction

  function automatic logic [7:0] any_alpha();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b2);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == a || b == b2);
    return b;
  endfunction

  function automatic logic [7:0] any_crlf();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  function automatic void put(input logic [7:0] b);
    story_q.push_back({1'b0, b});
  endfunction

  function automatic void row(input logic [7:0] b, input logic eos);
    dir_row_t d;
    d.b = b;
    d.eos = eos;
    d.typed = 1'b0;
    d.want = '0;
    dir_rows.push_back(d);
  endfunction

  function automatic void row_typed(input logic [7:0] b, input logic eos, input tag_word_t want);
    dir_row_t d;
    d.b = b;
    d.eos = eos;
    d.typed = 1'b1;
    d.want = want;
    dir_rows.push_back(d);
  endfunction

  // mostly well formed stories with random content; some corrupted or cut
  task automatic build_story();
    int n, m, r, pos;
    logic [7:0] b;
    story_q.delete();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 2))
        0: put(CH_SYN);
        1: put(CH_CR);
        default: put(CH_LF);
      endcase
    end
    put(CH_SOH);
    if ($urandom_range(0, 1)) put(any_alpha());
    n = pick_len(3, 4);
    if (n == 0) n = 1;
    repeat (n) put(any_digit());
    if ($urandom_range(0, 99) < 30)
      repeat (pick_len(4, 16)) put($urandom_range(0, 1) ? any_alpha() : byte_except(CH_US, CH_US));
    put(CH_US);
    repeat (pick_len(3, 5)) put(($urandom_range(0, 5) == 0) ? CH_DASH : any_alpha());
    if ($urandom_range(0, 1)) put(CH_CR);
    put(CH_LF);
    put(any_alpha());
    put(CH_SP);
    put(any_alpha());
    put($urandom_range(0, 1) ? CH_DC3 : CH_DC4);
    put($urandom_range(0, 1) ? CH_DC1 : CH_DC2);
    put(CH_SP);
    repeat (pick_len(6, 24)) begin
      r = $urandom_range(0, 9);
      put((r < 6) ? any_alpha() : (r < 9) ? any_digit() : CH_DASH);
    end
    put(CH_SP);
    n = $urandom_range(0, 3);
    repeat (n) put(byte_except(CH_SP, CH_SP));
    put(CH_SP);
    m = $urandom_range(0, 3);
    if (n == 0) begin
      if ($urandom_range(0, 1)) put(CH_SP);
      else if (m == 0) m = 1;
    end
    repeat (m) put(byte_except(CH_SP, CH_SP));
    put(CH_SP);
    repeat (pick_len(4, 5)) put(($urandom_range(0, 4) == 0) ? CH_DASH : any_digit());
    put(CH_SP);
    repeat (pick_len(3, 4)) put(any_digit());
    case ($urandom_range(0, 3))
      0: ;
      1: put(CH_CR);
      2: put(CH_LF);
      default: begin
        put(CH_CR);
        put(CH_LF);
      end
    endcase
    put(CH_STX);
    repeat ($urandom_range(0, 10)) put(byte_except(CH_ETX, CH_ETX));
    put(CH_ETX);
    repeat ($urandom_range(0, 2)) put(any_crlf());
    repeat ($urandom_range(1, 5)) put(byte_except(CH_CR, CH_LF));
    repeat ($urandom_range(1, 2)) put(any_crlf());
    put(CH_EOT);
    repeat ($urandom_range(0, 2)) put(any_crlf());

    r = $urandom_range(0, 99);
    if (r < 12) begin
      pos = $urandom_range(0, story_q.size() - 1);
      b = 8'($urandom_range(0, 255));
      story_q[pos] = {1'b0, b};
    end else if (r < 22) begin
      pos = $urandom_range(0, story_q.size() - 1);
      while (story_q.size() > pos) void'(story_q.pop_back());
    end else if (r < 27) begin
      story_q.delete();
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        put(b);
      end
    end
    b = 8'($urandom_range(0, 255));
    story_q.push_back({1'b1, b});
  endtask

  // enters and leaves just after a falling edge
  task automatic send_word(input logic [7:0] b, input logic eos, input bit typed,
                           input tag_word_t want);
    int gap;
    tag_word_t pred;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    end_of_stream = eos;
    do @(posedge clk); while (!in_ready);
    pred = parse_byte(b, eos);
    pending_results.push_back(typed ? want : pred);
    sent_items++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    tag_word_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {field_tag, char_out, story_value, count_value, format_kind, status, error_code};
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) flag_mismatch("result mismatch", got, want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("news_wire_story_header_parser_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    clear_parser();

    // end of stream straight after reset, then garbage before SOH
    row_typed(8'hA5, 1'b1, '{TAG_DELIM, 8'h00, 14'd0, 14'd0, 3'd0, ST_ERROR, ERR_SOH});
    row_typed(8'hFF, 1'b0, '{TAG_DELIM, 8'hFF, 14'd0, 14'd0, 3'd0, ST_ERROR, ERR_SOH});
    row_typed(8'h5A, 1'b1, '{TAG_DELIM, 8'h00, 14'd0, 14'd0, 3'd0, ST_ERROR, ERR_SOH});
    // a full story at the numeric extremes, empty keyword, version,
    // reference and date, fifth story digit spilling into the UPI,
    // EOT standing as the time
    row(CH_SOH, 1'b0);
    repeat (5) row("9", 1'b0);
    row(CH_US, 1'b0);
    row(CH_LF, 1'b0);
    row("A", 1'b0);
    row(CH_SP, 1'b0);
    row("z", 1'b0);
    row(CH_DC4, 1'b0);
    row(CH_DC2, 1'b0);
    repeat (6) row(CH_SP, 1'b0);
    repeat (4) row("9", 1'b0);
    row(CH_STX, 1'b0);
    row(8'h80, 1'b0);
    row(CH_ETX, 1'b0);
    row(CH_LF, 1'b0);
    row(CH_EOT, 1'b0);
    row(CH_CR, 1'b0);
    row(CH_EOT, 1'b0);
    row_typed(8'h00, 1'b1,
              '{TAG_DELIM, 8'h00, 14'd9999, 14'd9999, KIND_AGATE_TAB, ST_DONE, ERR_NONE});

    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed,
                                    dir_rows[i].want);

    while (sent_items < TARGET_ITEMS) begin
      calm = ($urandom_range(0, 99) < 20);
      build_story();
      foreach (story_q[i]) send_word(story_q[i][7:0], story_q[i][8], 1'b0, '0);
    end
    in_valid = 1'b0;
    calm = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("news_wire_story_header_parser_core_tb: done, clean");
    end else begin
      $display("news_wire_story_header_parser_core_tb: done, errors");
    end
    $finish;
  end

endmodule
